>>> rtl/int_to_decimal_with_precision_core_macros.svh
// ----------------------------------------------------------------------------
// int_to_decimal_with_precision_core_macros
// assertion macros used by the checker file
// ----------------------------------------------------------------------------
`ifndef INT_TO_DECIMAL_WITH_PRECISION_CORE_MACROS_SVH
`define INT_TO_DECIMAL_WITH_PRECISION_CORE_MACROS_SVH

// same-cycle implication, clocked on clk, off while rst_n is low
`define I2D_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, clocked on clk, off while rst_n is low
`define I2D_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/i2d_pkg.sv
// ----------------------------------------------------------------------------
// i2d_pkg
// shared types and constants of the decimal text formatter
// ----------------------------------------------------------------------------
package i2d_pkg;

  localparam int VALUE_W       = 32;
  localparam int PREC_W        = 7;
  localparam int CHAR_W        = 8;
  localparam int NUM_DIGITS    = 10;
  localparam int DIGIT_W       = 4;
  localparam int BCD_W         = NUM_DIGITS * DIGIT_W;
  localparam int NDIG_W        = $clog2(NUM_DIGITS + 1);
  localparam int IN_DATA_W     = ((VALUE_W + PREC_W + 7) / 8) * 8;
  localparam int MAX_PRECISION = 62;

  localparam logic [CHAR_W-1:0] ASCII_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] ASCII_MINUS = 8'h2d;
  localparam logic [CHAR_W-1:0] ASCII_NINE  = 8'h39;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_CONV = 4'b0010,
    ST_PREP = 4'b0100,
    ST_EMIT = 4'b1000
  } i2d_state_t;

  typedef struct packed {
    logic busy;
    logic done;
  } i2d_conv_stat_t;

endpackage

>>> rtl/i2d_dabble.sv
// ----------------------------------------------------------------------------
// i2d_dabble
// bit-serial binary to bcd converter, one magnitude bit per cycle
// ----------------------------------------------------------------------------
module i2d_dabble (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [i2d_pkg::VALUE_W-1:0] mag_in,
  output i2d_pkg::i2d_conv_stat_t     stat,
  output logic [i2d_pkg::BCD_W-1:0]   bcd
);
  import i2d_pkg::*;

  localparam int CNT_W = $clog2(VALUE_W);

  logic [VALUE_W-1:0] mag_r, mag_nxt;
  logic [BCD_W-1:0]   bcd_r, bcd_nxt;
  logic [BCD_W-1:0]   bcd_adj;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic               busy_r, busy_nxt;
  logic               done_r, done_nxt;

  // add-3 correction on every digit before the shift
  always_comb begin
    for (int i = 0; i < NUM_DIGITS; i++) begin
      if (bcd_r[i*DIGIT_W +: DIGIT_W] >= 4'd5) begin
        bcd_adj[i*DIGIT_W +: DIGIT_W] = bcd_r[i*DIGIT_W +: DIGIT_W] + 4'd3;
      end else begin
        bcd_adj[i*DIGIT_W +: DIGIT_W] = bcd_r[i*DIGIT_W +: DIGIT_W];
      end
    end
  end

  always_comb begin
    mag_nxt  = mag_r;
    bcd_nxt  = bcd_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      mag_nxt  = mag_in;
      bcd_nxt  = '0;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      bcd_nxt = {bcd_adj[BCD_W-2:0], mag_r[VALUE_W-1]};
      mag_nxt = {mag_r[VALUE_W-2:0], 1'b0};
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CNT_W'(VALUE_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mag_r <= mag_nxt;
    bcd_r <= bcd_nxt;
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign bcd       = bcd_r;

endmodule

>>> rtl/int_to_decimal_with_precision_core.sv
// ----------------------------------------------------------------------------
// int_to_decimal_with_precision_core
// signed 32-bit integer to decimal ascii text with minimum digit count
// ----------------------------------------------------------------------------
// each item yields 1 to 63 characters, the empty-text marker counting as one
// load, bit-serial bcd conversion, handoff and digit count, then one char per unstalled cycle
// input is taken again as soon as the last character sits in the output register
// reset: synchronous, active low; clears the state machine and output valid
module int_to_decimal_with_precision_core #(
  parameter int MAX_PRECISION = i2d_pkg::MAX_PRECISION
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // input stream
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [i2d_pkg::IN_DATA_W-1:0] in_tdata,   // [31:0] value, [38:32] precision
  // result stream
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [i2d_pkg::CHAR_W-1:0]    out_tdata,  // [7:0] character
  output logic                          out_tuser,  // [0] char_valid
  output logic                          out_tlast   // is_last
);
  import i2d_pkg::*;

  // pad counter wide enough for the saturated precision
  localparam int PAD_W = $clog2(MAX_PRECISION + 1);

  i2d_state_t state_r, state_nxt;

  // input fields
  logic [VALUE_W-1:0] in_value;
  logic [PREC_W-1:0]  in_prec;
  logic               in_xfer;
  logic [VALUE_W-1:0] mag;

  // converter
  i2d_conv_stat_t     conv_stat;
  logic [BCD_W-1:0]   bcd;

  // item context
  logic               neg_r, neg_nxt;
  logic [PAD_W-1:0]   prec_r, prec_nxt;
  logic [PAD_W-1:0]   pad_r, pad_nxt;
  logic [NDIG_W-1:0]  dig_r, dig_nxt;
  logic [NDIG_W-1:0]  nd;
  logic [PAD_W-1:0]   nd_ext;
  logic [DIGIT_W-1:0] cur_digit;

  // output register
  logic               out_tvalid_r, out_tvalid_nxt;
  logic [CHAR_W-1:0]  char_r, char_nxt;
  logic               cvalid_r, cvalid_nxt;
  logic               last_r, last_nxt;
  logic               emit;

  assign in_value = in_tdata[VALUE_W-1:0];
  assign in_prec  = in_tdata[VALUE_W +: PREC_W];
  assign in_tready = (state_r == ST_IDLE);
  assign in_xfer   = in_tvalid && in_tready;

  // magnitude in 32-bit unsigned arithmetic, so the most negative value wraps to itself
  assign mag = in_value[VALUE_W-1] ? (VALUE_W'(0) - in_value) : in_value;

  i2d_dabble u_dabble (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (in_xfer),
    .mag_in (mag),
    .stat   (conv_stat),
    .bcd    (bcd)
  );

  // significant digit count: index of the highest nonzero digit plus one
  always_comb begin
    nd = '0;
    for (int i = 0; i < NUM_DIGITS; i++) begin
      if (bcd[i*DIGIT_W +: DIGIT_W] != '0) begin
        nd = NDIG_W'(i + 1);
      end
    end
  end

  assign nd_ext    = PAD_W'(nd);
  assign cur_digit = bcd[(dig_r - 1'b1) * DIGIT_W +: DIGIT_W];

  // a character moves into the output register when it is free or being drained
  assign emit = (state_r == ST_EMIT) && (!out_tvalid_r || out_tready);

  always_comb begin
    state_nxt      = state_r;
    neg_nxt        = neg_r;
    prec_nxt       = prec_r;
    pad_nxt        = pad_r;
    dig_nxt        = dig_r;
    out_tvalid_nxt = out_tvalid_r;
    char_nxt       = char_r;
    cvalid_nxt     = cvalid_r;
    last_nxt       = last_r;

    if (out_tvalid_r && out_tready) begin
      out_tvalid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_xfer) begin
          neg_nxt = in_value[VALUE_W-1];
          // no precision given acts as one digit minimum, which only matters for zero
          if (in_prec[PREC_W-1]) begin
            prec_nxt = PAD_W'(1);
          end else if (in_prec > PREC_W'(MAX_PRECISION)) begin
            prec_nxt = PAD_W'(MAX_PRECISION);
          end else begin
            prec_nxt = PAD_W'(in_prec);
          end
          state_nxt = ST_CONV;
        end
      end
      ST_CONV: begin
        if (conv_stat.done) begin
          state_nxt = ST_PREP;
        end
      end
      ST_PREP: begin
        pad_nxt   = (prec_r > nd_ext) ? (prec_r - nd_ext) : '0;
        dig_nxt   = nd;
        state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (emit) begin
          out_tvalid_nxt = 1'b1;
          cvalid_nxt     = 1'b1;
          if (neg_r) begin
            // sign first
            char_nxt = ASCII_MINUS;
            last_nxt = (pad_r == '0) && (dig_r == '0);
            neg_nxt  = 1'b0;
          end else if (pad_r != '0) begin
            // leading zero padding
            char_nxt = ASCII_ZERO;
            last_nxt = (pad_r == PAD_W'(1)) && (dig_r == '0);
            pad_nxt  = pad_r - 1'b1;
          end else if (dig_r != '0) begin
            // digits, most significant first
            char_nxt = ASCII_ZERO + CHAR_W'(cur_digit);
            last_nxt = (dig_r == NDIG_W'(1));
            dig_nxt  = dig_r - 1'b1;
          end else begin
            // empty text: zero value with precision zero
            char_nxt   = '0;
            cvalid_nxt = 1'b0;
            last_nxt   = 1'b1;
          end
          if (last_nxt) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  // payload and item context, no reset needed
  always_ff @(posedge clk) begin
    neg_r    <= neg_nxt;
    prec_r   <= prec_nxt;
    pad_r    <= pad_nxt;
    dig_r    <= dig_nxt;
    char_r   <= char_nxt;
    cvalid_r <= cvalid_nxt;
    last_r   <= last_nxt;
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = char_r;
  assign out_tuser  = cvalid_r;
  assign out_tlast  = last_r;

endmodule

>>> rtl/i2d_checker.sv
// ----------------------------------------------------------------------------
// i2d_checker
// port-level checks of the decimal text formatter, bound to the top level
// ----------------------------------------------------------------------------
`include "int_to_decimal_with_precision_core_macros.svh"

module i2d_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_tvalid,
  input logic                          in_tready,
  input logic [i2d_pkg::IN_DATA_W-1:0] in_tdata,
  input logic                          out_tvalid,
  input logic                          out_tready,
  input logic [i2d_pkg::CHAR_W-1:0]    out_tdata,
  input logic                          out_tuser,
  input logic                          out_tlast
);
  import i2d_pkg::*;

  logic in_xfer;
  logic out_stall;
  logic in_seen;

  assign in_xfer   = in_tvalid && in_tready;
  assign out_stall = out_tvalid && !out_tready;
  assign in_seen   = in_xfer && (in_tdata != '0 || in_tdata == '0);

  // conversion keeps the input busy, so no second item right behind the first
  `I2D_ASSERT_NEXT(a_busy_after_in, in_seen, !in_tready, "input taken twice in a row")

  // an empty-text marker always closes the text
  `I2D_ASSERT_NOW(a_empty_is_last, out_tvalid && !out_tuser, out_tlast, "empty text not last")

  // every meaningful character is a sign or a decimal digit
  `I2D_ASSERT_NOW(a_char_range, out_tvalid && out_tuser,
    (out_tdata == ASCII_MINUS) || ((out_tdata >= ASCII_ZERO) && (out_tdata <= ASCII_NINE)),
    "character outside sign and digits")

  // a stalled result holds
  `I2D_ASSERT_NEXT(a_out_hold, out_stall,
    out_tvalid && $stable(out_tdata) && $stable(out_tuser) && $stable(out_tlast),
    "stalled result changed")

endmodule

bind int_to_decimal_with_precision_core i2d_checker u_i2d_checker (.*);

>>> verif/int_to_decimal_with_precision_core_test.sv
// ----------------------------------------------------------------------------
// int_to_decimal_with_precision_core_test
// self-checking bench for the signed decimal text formatter
// ----------------------------------------------------------------------------
// drives value/precision items into the input stream and checks every
// emitted character against table text or a local "%.Nd" model. a short
// table of directed items comes first, then a long random run with bursty
// input traffic and an output side that stalls in changing patterns.
// ----------------------------------------------------------------------------
module int_to_decimal_with_precision_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  import i2d_pkg::*;

  localparam int NUM_RANDOM = 350;
  localparam int NUM_DIRECTED = 22;
  localparam int DRAIN_CYCLES = 64;  // extra wait to catch stray characters after the last expected one

  // one expected character transfer
  typedef struct {
    logic [CHAR_W-1:0] ch;
    logic              char_valid;
    logic              is_last;
  } char_result_t;

  // one directed item; typed rows carry the expected text, others use the model
  typedef struct {
    logic [VALUE_W-1:0] value;
    int                 prec;
    bit                 typed;
    string              text;
  } stim_row_t;

  logic                 clk;
  logic                 rst_n = 1'b0;
  logic                 in_tvalid = 1'b0;
  logic                 in_tready;
  logic [IN_DATA_W-1:0] in_tdata = '0;   // [31:0] value, [38:32] precision
  logic                 out_tvalid;
  logic                 out_tready = 1'b0;
  logic [CHAR_W-1:0]    out_tdata;       // [7:0] character
  logic                 out_tuser;       // [0] char_valid
  logic                 out_tlast;

  char_result_t pending_chars [$];
  char_result_t head_char;
  int           fail_count = 0;
  int           burst_left = 0;

  // receiver stall pattern state
  int rx_mode = 0;
  int rx_left = 0;
  int rx_stall = 0;

  // directed table: extremes, zero cases, empty text, odd precisions
  stim_row_t dir_rows [NUM_DIRECTED] = '{
    '{32'd0,          -1,  1'b1, "0"},
    '{32'd0,           0,  1'b1, ""},             // empty text
    '{32'd0,           1,  1'b1, "0"},
    '{32'd0,           5,  1'b1, "00000"},
    '{32'h7fffffff,   -1,  1'b1, "2147483647"},
    '{32'h80000000,   -1,  1'b1, "-2147483648"},  // most negative, widened
    '{32'h80000000,   12,  1'b1, "-002147483648"},
    '{32'hffffffff,   -1,  1'b1, "-1"},
    '{32'd1,           0,  1'b1, "1"},
    '{32'd42,        -64,  1'b1, "42"},           // other negative precision
    '{32'(-5),         3,  1'b1, "-005"},
    '{32'd123456789,   9,  1'b1, "123456789"},
    '{32'd0,          62,  1'b0, ""},
    '{32'd0,          63,  1'b0, ""},             // precision saturates
    '{32'hffffffff,   62,  1'b0, ""},
    '{32'h7fffffff,   63,  1'b0, ""},
    '{32'h80000000,   63,  1'b0, ""},
    '{32'd1000000000, 10,  1'b0, ""},
    '{32'd999999999,  11,  1'b0, ""},
    '{32'(-10),        2,  1'b0, ""},
    '{32'd9,           1,  1'b0, ""},
    '{32'd0,          -2,  1'b0, ""}
  };

  int_to_decimal_with_precision_core u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // queue one expected character
  function automatic void push_char(input logic [CHAR_W-1:0] ch, input logic vld,
                                    input logic last);
    char_result_t r;
    r.ch = ch;
    r.char_valid = vld;
    r.is_last = last;
    pending_chars.push_back(r);
  endfunction

  // expected text typed in a table row; empty string means the empty result
  function automatic void push_text(input string text);
    int n;
    n = text.len();
    if (n == 0) begin
      push_char('0, 1'b0, 1'b1);
      return;
    end
    for (int i = 0; i < n; i++) push_char(text[i], 1'b1, i == n - 1);
  endfunction

  // printf style "%.Nd" of one item, characters queued most significant first
  function automatic void format_decimal(input logic [VALUE_W-1:0] raw,
                                         input logic [PREC_W-1:0] p7);
    logic               neg;
    int                 prec;
    int                 width;
    int                 nd;
    int                 pad;
    int                 total;
    int                 k;
    logic [VALUE_W-1:0] mag;
    logic [3:0]         digs [NUM_DIGITS];
    neg = raw[VALUE_W-1];
    // top bit set means any negative precision, i.e. none given
    if (p7[PREC_W-1]) prec = -1;
    else if (int'(p7) > MAX_PRECISION) prec = MAX_PRECISION;
    else prec = int'(p7);
    // unsigned negate keeps the most negative value intact
    mag = neg ? (32'd0 - raw) : raw;
    if (mag == 0) begin
      if (prec == 0) begin
        push_char('0, 1'b0, 1'b1);
        return;
      end
      width = (prec > 1) ? prec : 1;
      for (int i = 0; i < width; i++) push_char(ASCII_ZERO, 1'b1, i == width - 1);
      return;
    end
    nd = 0;
    while (mag != 0 && nd < NUM_DIGITS) begin
      digs[nd] = 4'(mag % 10);
      mag = mag / 10;
      nd++;
    end
    pad = (prec > nd) ? (prec - nd) : 0;
    total = (neg ? 1 : 0) + pad + nd;
    k = 0;
    if (neg) begin
      push_char(ASCII_MINUS, 1'b1, k == total - 1);
      k++;
    end
    for (int i = 0; i < pad; i++) begin
      push_char(ASCII_ZERO, 1'b1, k == total - 1);
      k++;
    end
    for (int i = nd - 1; i >= 0; i--) begin
      push_char(ASCII_ZERO + CHAR_W'(digs[i]), 1'b1, k == total - 1);
      k++;
    end
  endfunction

  // random value: full range, small magnitudes, decade edges and extremes
  function automatic logic [VALUE_W-1:0] rand_value();
    int                 pick;
    int                 dec;
    logic [VALUE_W-1:0] p10;
    pick = $urandom_range(0, 15);
    if (pick < 5) return $urandom();
    if (pick < 8) return VALUE_W'($urandom_range(0, 999));
    if (pick < 10) return 32'd0 - VALUE_W'($urandom_range(1, 999));
    if (pick < 13) begin
      // a power of ten or one either side of it, either sign
      dec = $urandom_range(0, 9);
      p10 = 32'd1;
      repeat (dec) p10 = p10 * 10;
      p10 = p10 + VALUE_W'($urandom_range(0, 2)) - 32'd1;
      return $urandom_range(0, 1) ? (32'd0 - p10) : p10;
    end
    if (pick == 13) return 32'd0;
    case ($urandom_range(0, 2))
      0: return 32'h80000000;
      1: return 32'h80000001;
      default: return 32'h7fffffff;
    endcase
  endfunction

  // random precision: mostly none or small, some large, saturating or odd
  function automatic logic [PREC_W-1:0] rand_prec();
    int pick;
    pick = $urandom_range(0, 19);
    if (pick < 7) return 7'h7f;                            // none given
    if (pick < 14) return PREC_W'($urandom_range(0, 12));
    if (pick < 17) return PREC_W'($urandom_range(13, 62));
    if (pick == 17) return PREC_W'(63);                    // above the cap
    return PREC_W'($urandom_range(64, 126));               // other negatives
  endfunction

  // one input transfer, with bursts and random gaps in front of it
  task automatic send_item(input logic [VALUE_W-1:0] value, input logic [PREC_W-1:0] prec,
                           input bit typed, input string text);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 12);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      // now and then a long stretch with no gaps at all
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60)
                                               : $urandom_range(1, 8);
    end
    burst_left--;
    in_tdata  <= {1'b0, prec, value};
    in_tvalid <= 1'b1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    // transfer done at this edge
    if (typed) push_text(text);
    else format_decimal(value, prec);
  endtask

  // result side: check each transfer, then choose ready for the next edge
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_chars.size() == 0) begin
        $error("unexpected result transfer: character %0h", out_tdata);
        fail_count++;
      end else begin
        head_char = pending_chars.pop_front();
        if (out_tdata !== head_char.ch) begin
          $error("character: expected %0h, actual %0h", head_char.ch, out_tdata);
          fail_count++;
        end
        if (out_tuser !== head_char.char_valid) begin
          $error("char_valid: expected %0b, actual %0b", head_char.char_valid, out_tuser);
          fail_count++;
        end
        if (out_tlast !== head_char.is_last) begin
          $error("is_last: expected %0b, actual %0b", head_char.is_last, out_tlast);
          fail_count++;
        end
      end
    end
    // stall pattern: switch modes every so often
    if (rx_left == 0) begin
      rx_mode = $urandom_range(0, 3);
      rx_left = $urandom_range(16, 200);
    end
    rx_left--;
    case (rx_mode)
      0: out_tready <= 1'b1;                         // no stalls
      1: out_tready <= 1'($urandom_range(0, 1));     // coin flip
      2: out_tready <= ($urandom_range(0, 3) == 0);  // mostly stalled
      default: begin
        // stall runs of random length, drawn after a ready cycle
        if (rx_stall > 0) begin
          rx_stall--;
          out_tready <= 1'b0;
        end else begin
          out_tready <= 1'b1;
          if ($urandom_range(0, 5) == 0) rx_stall = $urandom_range(1, 8);
        end
      end
    endcase
  end

  // stimulus and end of run
  initial begin
    rst_n <= 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    foreach (dir_rows[i])
      send_item(dir_rows[i].value, PREC_W'(dir_rows[i].prec), dir_rows[i].typed,
                dir_rows[i].text);
    repeat (NUM_RANDOM) send_item(rand_value(), rand_prec(), 1'b0, "");
    in_tvalid <= 1'b0;
    while (pending_chars.size() != 0) @(posedge clk);
    // catch any stray character after the last expected one
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // hang guard
  initial begin
    #20ms;
    $display("FAILURE");
    $finish;
  end

endmodule
